// ===== rtl/core/stt_pkg.sv =====
// Package: token codes, scan modes, pending operators and shared types.
package stt_pkg;
  localparam int MaxText = 32;
  localparam int CntW = $clog2(MaxText + 1);
  localparam int AddrW = (MaxText > 1) ? $clog2(MaxText) : 1;

  localparam logic [4:0] K_PLUS = 5'd0;
  localparam logic [4:0] K_MINUS = 5'd1;
  localparam logic [4:0] K_ASTERISK = 5'd2;
  localparam logic [4:0] K_SLASH = 5'd3;
  localparam logic [4:0] K_PERCENT = 5'd4;
  localparam logic [4:0] K_ASSIGN = 5'd5;
  localparam logic [4:0] K_EQUAL = 5'd6;
  localparam logic [4:0] K_NOT_EQUAL = 5'd7;
  localparam logic [4:0] K_LESS = 5'd8;
  localparam logic [4:0] K_LESS_EQUAL = 5'd9;
  localparam logic [4:0] K_GREATER = 5'd10;
  localparam logic [4:0] K_GREATER_EQUAL = 5'd11;
  localparam logic [4:0] K_EXCL = 5'd12;
  localparam logic [4:0] K_LPAREN = 5'd13;
  localparam logic [4:0] K_RPAREN = 5'd14;
  localparam logic [4:0] K_LBRACE = 5'd15;
  localparam logic [4:0] K_RBRACE = 5'd16;
  localparam logic [4:0] K_COLON = 5'd17;
  localparam logic [4:0] K_INT = 5'd18;
  localparam logic [4:0] K_FLOAT = 5'd19;
  localparam logic [4:0] K_STRING = 5'd20;
  localparam logic [4:0] K_IDENT = 5'd21;
  localparam logic [4:0] K_AND = 5'd22;
  localparam logic [4:0] K_OR = 5'd23;
  localparam logic [4:0] K_IF = 5'd24;
  localparam logic [4:0] K_ELSE = 5'd25;
  localparam logic [4:0] K_WHILE = 5'd26;
  localparam logic [4:0] K_FOR = 5'd27;
  localparam logic [4:0] K_EOL = 5'd28;
  localparam logic [4:0] K_EOF = 5'd29;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_IDENT = 3'd1;
  localparam logic [2:0] M_NUMBER = 3'd2;
  localparam logic [2:0] M_STRING = 3'd3;
  localparam logic [2:0] M_COMMENT = 3'd4;

  localparam logic [2:0] P_NONE = 3'd0;
  localparam logic [2:0] P_SLASH = 3'd1;
  localparam logic [2:0] P_ASSIGN = 3'd2;
  localparam logic [2:0] P_LESS = 3'd3;
  localparam logic [2:0] P_GREATER = 3'd4;
  localparam logic [2:0] P_EXCL = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic             clear;    // new text token
    logic             store;    // append character
    logic             set_float;
    logic             rd_en;    // issue buffer read
    logic [AddrW-1:0] rd_addr;
  } stt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            truncated;
    logic            float_seen;
    logic [4:0]      word_kind;  // keyword code or K_IDENT
    logic [7:0]      rd_data;
  } stt_sts_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [4:0] short_form(input logic [2:0] p);
    case (p)
      P_SLASH: return K_SLASH;
      P_ASSIGN: return K_ASSIGN;
      P_LESS: return K_LESS;
      P_GREATER: return K_GREATER;
      default: return K_EXCL;
    endcase
  endfunction

  function automatic logic [4:0] long_form(input logic [2:0] p);
    case (p)
      P_ASSIGN: return K_EQUAL;
      P_LESS: return K_LESS_EQUAL;
      P_GREATER: return K_GREATER_EQUAL;
      default: return K_NOT_EQUAL;
    endcase
  endfunction
endpackage

// ===== rtl/core/stt_if.sv =====
// Channel interfaces: input character words and token result words.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] source_char;
  modport source (output valid, kind, source_char, input ready);
  modport sink (input valid, kind, source_char, output ready);
endinterface

interface stt_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_kind;
  logic       is_text;
  logic [7:0] text_char;
  logic [5:0] text_len;
  logic       overflow;
  logic       last;
  modport source (output valid, token_kind, is_text, text_char, text_len, overflow, last,
                  input ready);
  modport sink (input valid, token_kind, is_text, text_char, text_len, overflow, last,
                output ready);
endinterface

// ===== rtl/core/stt_ram.sv =====
// Generic single-port-write, registered-read RAM.
module stt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem_r[rd_addr];
  end
endmodule

// ===== rtl/core/stt_datapath.sv =====
// Datapath: text buffer, count, flags and keyword match.
module stt_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        ch,
  input  stt_pkg::stt_cmd_t cmd,
  output stt_pkg::stt_sts_t sts
);
  logic [stt_pkg::CntW-1:0] count_r, count_nxt;
  logic trunc_r, trunc_nxt, float_r, float_nxt;
  logic [7:0] c0_r, c1_r, c2_r, c3_r, c4_r;
  logic wr_en;
  logic [4:0] wk;

  assign wr_en = cmd.store && (count_r < stt_pkg::CntW'(stt_pkg::MaxText));

  always_comb begin
    count_nxt = count_r;
    trunc_nxt = trunc_r;
    float_nxt = float_r;
    if (cmd.clear) begin
      count_nxt = '0;
      trunc_nxt = 1'b0;
      float_nxt = 1'b0;
    end else begin
      if (cmd.store) begin
        if (wr_en) count_nxt = count_r + 1'b1;
        else trunc_nxt = 1'b1;
      end
      if (cmd.set_float) float_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      trunc_r <= 1'b0;
      float_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      trunc_r <= trunc_nxt;
      float_r <= float_nxt;
    end
  end

  // shadow copy of the first five characters for keyword compare
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (count_r)
        stt_pkg::CntW'(0): c0_r <= ch;
        stt_pkg::CntW'(1): c1_r <= ch;
        stt_pkg::CntW'(2): c2_r <= ch;
        stt_pkg::CntW'(3): c3_r <= ch;
        stt_pkg::CntW'(4): c4_r <= ch;
        default: ;
      endcase
    end
  end

  always_comb begin
    wk = stt_pkg::K_IDENT;
    if (!trunc_r) begin
      if (count_r == stt_pkg::CntW'(3) && c0_r == "a" && c1_r == "n" && c2_r == "d")
        wk = stt_pkg::K_AND;
      else if (count_r == stt_pkg::CntW'(2) && c0_r == "o" && c1_r == "r")
        wk = stt_pkg::K_OR;
      else if (count_r == stt_pkg::CntW'(2) && c0_r == "i" && c1_r == "f")
        wk = stt_pkg::K_IF;
      else if (count_r == stt_pkg::CntW'(4) && c0_r == "e" && c1_r == "l" &&
               c2_r == "s" && c3_r == "e")
        wk = stt_pkg::K_ELSE;
      else if (count_r == stt_pkg::CntW'(5) && c0_r == "w" && c1_r == "h" &&
               c2_r == "i" && c3_r == "l" && c4_r == "e")
        wk = stt_pkg::K_WHILE;
      else if (count_r == stt_pkg::CntW'(3) && c0_r == "f" && c1_r == "o" && c2_r == "r")
        wk = stt_pkg::K_FOR;
    end
  end

  stt_ram #(.Width(8), .Depth(stt_pkg::MaxText)) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[stt_pkg::AddrW-1:0]),
    .wr_data (ch),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (sts.rd_data)
  );

  assign sts.count = count_r;
  assign sts.truncated = trunc_r;
  assign sts.float_seen = float_r;
  assign sts.word_kind = wk;
endmodule

// ===== rtl/core/stt_ctrl.sv =====
// Controller: scan state, input decode and result word sequencing.
module stt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  stt_in_if.sink            in_ch,
  stt_out_if.source         out_ch,
  output logic [7:0]        ch,
  output stt_pkg::stt_cmd_t cmd,
  input  stt_pkg::stt_sts_t sts
);
  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for word
  localparam logic [2:0] S_PRE  = 3'd1;  // emit short operator / keyword / value header
  localparam logic [2:0] S_TEXT = 3'd2;  // replay buffered text
  localparam logic [2:0] S_POST = 3'd3;  // act on character afresh, store a started token's first character
  localparam logic [2:0] S_TAIL = 3'd4;  // emit single tail token

  logic [2:0] st_r, st_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic [2:0] pend_r, pend_nxt;
  logic       eot_r, eot_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic       hv_r, hv_nxt;        // header token present
  logic [4:0] hk_r, hk_nxt;        // header token kind
  logic       fresh_r, fresh_nxt;  // run fresh handling after header/text
  logic [4:0] tk_r, tk_nxt;        // tail token kind
  logic       tv_r, tv_nxt;        // tail token present
  logic [stt_pkg::CntW-1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  logic [4:0] o_kind_r, o_kind_nxt;
  logic       o_text_r, o_text_nxt;
  logic [7:0] o_char_r, o_char_nxt;
  logic [5:0] o_len_r, o_len_nxt;
  logic       o_ovf_r, o_ovf_nxt;
  logic       o_last_r, o_last_nxt;
  logic       o_busy, acc;
  logic       pv_r, pv_nxt;        // rd data pending for text word

  assign o_busy = ov_r && !out_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign ch = acc ? in_ch.source_char : ch_r;

  assign out_ch.valid = ov_r;
  assign out_ch.token_kind = o_kind_r;
  assign out_ch.is_text = o_text_r;
  assign out_ch.text_char = o_char_r;
  assign out_ch.text_len = o_len_r;
  assign out_ch.overflow = o_ovf_r;
  assign out_ch.last = o_last_r;

  // fresh character decode: returns single token or new pending / mode
  function automatic void fresh(input logic [7:0] c, output logic tok_v,
                                output logic [4:0] tok, output logic [2:0] pend,
                                output logic [2:0] mode, output logic clr,
                                output logic st);
    tok_v = 1'b0; tok = stt_pkg::K_EOL; pend = stt_pkg::P_NONE;
    mode = stt_pkg::M_IDLE; clr = 1'b0; st = 1'b0;
    case (c)
      8'h0a: begin tok_v = 1'b1; tok = stt_pkg::K_EOL; end
      "/": pend = stt_pkg::P_SLASH;
      "=": pend = stt_pkg::P_ASSIGN;
      "<": pend = stt_pkg::P_LESS;
      ">": pend = stt_pkg::P_GREATER;
      "!": pend = stt_pkg::P_EXCL;
      8'h22, 8'h27: begin clr = 1'b1; mode = stt_pkg::M_STRING; end
      ":": begin tok_v = 1'b1; tok = stt_pkg::K_COLON; end
      "+": begin tok_v = 1'b1; tok = stt_pkg::K_PLUS; end
      "-": begin tok_v = 1'b1; tok = stt_pkg::K_MINUS; end
      "%": begin tok_v = 1'b1; tok = stt_pkg::K_PERCENT; end
      "*": begin tok_v = 1'b1; tok = stt_pkg::K_ASTERISK; end
      "(": begin tok_v = 1'b1; tok = stt_pkg::K_LPAREN; end
      ")": begin tok_v = 1'b1; tok = stt_pkg::K_RPAREN; end
      "{": begin tok_v = 1'b1; tok = stt_pkg::K_LBRACE; end
      "}": begin tok_v = 1'b1; tok = stt_pkg::K_RBRACE; end
      default: begin
        if (stt_pkg::is_letter(c)) begin
          clr = 1'b1; st = 1'b1; mode = stt_pkg::M_IDENT;
        end else if (stt_pkg::is_digit(c)) begin
          clr = 1'b1; st = 1'b1; mode = stt_pkg::M_NUMBER;
        end
      end
    endcase
  endfunction

  always_comb begin
    logic f_v, f_clr, f_st;
    logic [4:0] f_tok;
    logic [2:0] f_pend, f_mode;
    logic [stt_pkg::CntW-1:0] n;
    logic emit;
    f_v = 1'b0; f_clr = 1'b0; f_st = 1'b0; f_tok = stt_pkg::K_EOL;
    f_pend = stt_pkg::P_NONE; f_mode = stt_pkg::M_IDLE; emit = 1'b0;
    // decode of the held character, also tells whether a tail token follows
    fresh(ch_r, f_v, f_tok, f_pend, f_mode, f_clr, f_st);
    n = sts.truncated ? stt_pkg::CntW'(stt_pkg::MaxText) : sts.count;
    st_nxt = st_r; mode_nxt = mode_r; pend_nxt = pend_r; eot_nxt = eot_r;
    ch_nxt = ch_r; hv_nxt = hv_r; hk_nxt = hk_r; fresh_nxt = fresh_r;
    tk_nxt = tk_r; tv_nxt = tv_r; idx_nxt = idx_r; pv_nxt = 1'b0;
    cmd = '0;
    cmd.rd_addr = idx_r[stt_pkg::AddrW-1:0];
    ov_nxt = ov_r && !out_ch.ready;
    o_kind_nxt = o_kind_r; o_text_nxt = o_text_r; o_char_nxt = o_char_r;
    o_len_nxt = o_len_r; o_ovf_nxt = o_ovf_r; o_last_nxt = o_last_r;

    case (st_r)
      S_IDLE: begin
        if (acc) begin
          ch_nxt = in_ch.source_char;
          eot_nxt = in_ch.kind;
          hv_nxt = 1'b0; fresh_nxt = 1'b0; tv_nxt = 1'b0;
          st_nxt = S_PRE;
          if (in_ch.kind) begin
            tv_nxt = 1'b1; tk_nxt = stt_pkg::K_EOF;
            if (mode_r == stt_pkg::M_IDENT) begin
              hv_nxt = 1'b1; hk_nxt = sts.word_kind;
            end else if (mode_r == stt_pkg::M_NUMBER) begin
              hv_nxt = 1'b1;
              hk_nxt = sts.float_seen ? stt_pkg::K_FLOAT : stt_pkg::K_INT;
            end else if (mode_r == stt_pkg::M_IDLE && pend_r != stt_pkg::P_NONE &&
                         pend_r <= stt_pkg::P_EXCL) begin
              hv_nxt = 1'b1; hk_nxt = stt_pkg::short_form(pend_r);
            end
            mode_nxt = stt_pkg::M_IDLE; pend_nxt = stt_pkg::P_NONE;
          end else begin
            case (mode_r)
              stt_pkg::M_COMMENT: begin
                if (in_ch.source_char == 8'h0a) begin
                  tv_nxt = 1'b1; tk_nxt = stt_pkg::K_EOL; mode_nxt = stt_pkg::M_IDLE;
                end
              end
              stt_pkg::M_STRING: begin
                if (in_ch.source_char == 8'h22 || in_ch.source_char == 8'h27) begin
                  hv_nxt = 1'b1; hk_nxt = stt_pkg::K_STRING; mode_nxt = stt_pkg::M_IDLE;
                end else cmd.store = 1'b1;
              end
              stt_pkg::M_IDENT: begin
                if (stt_pkg::is_letter(in_ch.source_char) ||
                    stt_pkg::is_digit(in_ch.source_char)) cmd.store = 1'b1;
                else begin
                  hv_nxt = 1'b1; hk_nxt = sts.word_kind; fresh_nxt = 1'b1;
                  mode_nxt = stt_pkg::M_IDLE;
                end
              end
              stt_pkg::M_NUMBER: begin
                if (stt_pkg::is_digit(in_ch.source_char)) cmd.store = 1'b1;
                else if (in_ch.source_char == ".") begin
                  cmd.store = 1'b1; cmd.set_float = 1'b1;
                end else begin
                  hv_nxt = 1'b1; fresh_nxt = 1'b1; mode_nxt = stt_pkg::M_IDLE;
                  hk_nxt = sts.float_seen ? stt_pkg::K_FLOAT : stt_pkg::K_INT;
                end
              end
              default: begin
                mode_nxt = stt_pkg::M_IDLE;
                pend_nxt = stt_pkg::P_NONE;
                if (pend_r == stt_pkg::P_NONE || pend_r > stt_pkg::P_EXCL) begin
                  fresh_nxt = 1'b1;
                end else if (pend_r == stt_pkg::P_SLASH) begin
                  if (in_ch.source_char == "/") mode_nxt = stt_pkg::M_COMMENT;
                  else begin
                    hv_nxt = 1'b1; hk_nxt = stt_pkg::K_SLASH; fresh_nxt = 1'b1;
                  end
                end else if (in_ch.source_char == "=") begin
                  tv_nxt = 1'b1; tk_nxt = stt_pkg::long_form(pend_r);
                end else begin
                  hv_nxt = 1'b1; hk_nxt = stt_pkg::short_form(pend_r); fresh_nxt = 1'b1;
                end
              end
            endcase
          end
        end
      end
      S_PRE: begin
        // hv_r set: operator header or value header; value if kind has text
        if (!hv_r) st_nxt = S_POST;
        else if (!o_busy) begin
          emit = 1'b1;
          o_kind_nxt = hk_r; o_text_nxt = 1'b0; o_char_nxt = '0;
          if (hk_r == stt_pkg::K_INT || hk_r == stt_pkg::K_FLOAT ||
              hk_r == stt_pkg::K_STRING || hk_r == stt_pkg::K_IDENT) begin
            o_len_nxt = 6'(n); o_ovf_nxt = sts.truncated;
            idx_nxt = '0;
            if (n != '0) begin
              cmd.rd_en = 1'b1; cmd.rd_addr = '0; pv_nxt = 1'b1;
            end
            o_last_nxt = (n == '0) && !(fresh_r && f_v) && !tv_r;
            st_nxt = (n == '0) ? S_POST : S_TEXT;
          end else begin
            o_len_nxt = '0; o_ovf_nxt = 1'b0;
            o_last_nxt = !(fresh_r && f_v) && !tv_r;
            st_nxt = S_POST;
          end
        end
      end
      S_TEXT: begin
        if (pv_r || !o_busy) begin
          if (!pv_r) begin
            cmd.rd_en = 1'b1; pv_nxt = 1'b1;
          end else if (!o_busy) begin
            emit = 1'b1;
            o_kind_nxt = hk_r; o_text_nxt = 1'b1; o_char_nxt = sts.rd_data;
            o_len_nxt = '0; o_ovf_nxt = 1'b0;
            o_last_nxt = (idx_r + 1'b1 == n) && !(fresh_r && f_v) && !tv_r;
            idx_nxt = idx_r + 1'b1;
            if (idx_r + 1'b1 == n) st_nxt = S_POST;
          end else pv_nxt = 1'b1;
        end
      end
      S_POST: begin
        if (fresh_r) begin
          pend_nxt = f_pend; mode_nxt = f_mode;
          cmd.clear = f_clr;
          fresh_nxt = 1'b0;
          if (f_v) begin tv_nxt = 1'b1; tk_nxt = f_tok; end
          if (f_st) st_nxt = S_POST; // store next cycle after clear
          else st_nxt = S_TAIL;
          if (f_st) begin hv_nxt = 1'b0; tv_nxt = 1'b0; end
          hv_nxt = f_st; // reuse as store-pending flag
        end else if (hv_r && !eot_r && st_r == S_POST && mode_r != stt_pkg::M_IDLE &&
                     mode_r != stt_pkg::M_STRING) begin
          cmd.store = 1'b1; hv_nxt = 1'b0; st_nxt = S_TAIL;
        end else st_nxt = S_TAIL;
      end
      S_TAIL: begin
        if (!tv_r) begin
          st_nxt = S_IDLE;
          if (eot_r) cmd.clear = 1'b1;
        end else if (!o_busy) begin
          emit = 1'b1;
          o_kind_nxt = tk_r; o_text_nxt = 1'b0; o_char_nxt = '0;
          o_len_nxt = '0; o_ovf_nxt = 1'b0; o_last_nxt = 1'b1;
          tv_nxt = 1'b0;
          st_nxt = S_IDLE;
          if (eot_r) cmd.clear = 1'b1;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (emit) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      mode_r <= stt_pkg::M_IDLE;
      pend_r <= stt_pkg::P_NONE;
      ov_r <= 1'b0;
      pv_r <= 1'b0;
      hv_r <= 1'b0;
      fresh_r <= 1'b0;
      tv_r <= 1'b0;
      eot_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      ov_r <= ov_nxt;
      pv_r <= pv_nxt;
      hv_r <= hv_nxt;
      fresh_r <= fresh_nxt;
      tv_r <= tv_nxt;
      eot_r <= eot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
    hk_r <= hk_nxt;
    tk_r <= tk_nxt;
    idx_r <= idx_nxt;
    o_kind_r <= o_kind_nxt;
    o_text_r <= o_text_nxt;
    o_char_r <= o_char_nxt;
    o_len_r <= o_len_nxt;
    o_ovf_r <= o_ovf_nxt;
    o_last_r <= o_last_nxt;
  end
endmodule

// ===== rtl/core/source_text_tokenizer_unit.sv =====
// Top level of the source text tokenizer.
// One input word (a character or an end-of-text mark) is handled at a time.
// A character that only extends a token, or that completes only single-word
// tokens, passes through the PRE, POST and TAIL states before the next accept.
// A value token adds, for each text character, a registered read of the
// 32-entry text buffer and then a load of the output word, and a letter or
// digit that starts a new token right after it adds a further POST step for
// its store. Output stalls hold the sequencer; the output register frees input
// handling once the last word is loaded.
module source_text_tokenizer_unit (
  input  logic clk,
  input  logic rst_n,
  stt_in_if.sink    in_ch,
  stt_out_if.source out_ch
);
  stt_pkg::stt_cmd_t cmd;
  stt_pkg::stt_sts_t sts;
  logic [7:0] ch;

  stt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .ch(ch), .cmd(cmd), .sts(sts)
  );

  stt_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ch(ch), .cmd(cmd), .sts(sts)
  );
endmodule

// ===== rtl/core/stt_checker.sv =====
// Port-level checker for the tokenizer, bound to the top level.
module stt_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_is_text,
  input logic [5:0] out_text_len,
  input logic       out_overflow,
  input logic [4:0] out_token_kind
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind))
    else $error("result word dropped under stall");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_text_len <= 6'd32)
    else $error("text length out of range");
  a_txt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_text |-> out_text_len == 6'd0 && !out_overflow)
    else $error("text word carries header fields");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= 5'd29)
    else $error("bad token kind");
  // one word at a time: ready drops after every accept
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in flight");
endmodule

bind source_text_tokenizer_unit stt_port_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_is_text(out_ch.is_text), .out_text_len(out_ch.text_len),
  .out_overflow(out_ch.overflow), .out_token_kind(out_ch.token_kind)
);

// ===== bench/stt_checker.sv =====
// Token checker: predicts tokenizer output words from accepted input words and compares.
`timescale 1ns / 100ps
module stt_checker (
  input  logic      clk,
  input  logic      rst_n,
  stt_in_if.sink    in_mon,
  stt_out_if.sink   out_mon,
  output int        fail_count,
  output int        pending_words
);
  typedef struct packed {
    logic [4:0] token_kind;
    logic       is_text;
    logic [7:0] text_char;
    logic [5:0] text_len;
    logic       overflow;
    logic       last;
  } token_word_t;

  token_word_t expected_tokens[$];
  token_word_t step_words[$];

  logic [2:0] mode_q;
  logic [2:0] op_q;
  logic [7:0] text_q[stt_pkg::MaxText];
  int         count_q;
  logic       float_q;
  logic       trunc_q;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void emit(input logic [4:0] k, input logic t, input logic [7:0] c,
                               input int n, input logic o);
    token_word_t w;
    w.token_kind = k;
    w.is_text = t;
    w.text_char = c;
    w.text_len = n[5:0];
    w.overflow = o;
    w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void emit_value(input logic [4:0] k);
    emit(k, 1'b0, 8'd0, count_q, trunc_q);
    for (int i = 0; i < count_q; i++) emit(k, 1'b1, text_q[i], 0, 1'b0);
  endfunction

  function automatic void clear_text();
    count_q = 0;
    float_q = 1'b0;
    trunc_q = 1'b0;
  endfunction

  function automatic void append(input logic [7:0] c);
    if (count_q < stt_pkg::MaxText) begin
      text_q[count_q] = c;
      count_q++;
    end else begin
      trunc_q = 1'b1;
    end
  endfunction

  function automatic logic word_matches(input string w);
    if (trunc_q || count_q != w.len()) return 1'b0;
    for (int i = 0; i < w.len(); i++) if (text_q[i] != w[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void close_word();
    if (word_matches("and")) emit(stt_pkg::K_AND, 0, 0, 0, 0);
    else if (word_matches("or")) emit(stt_pkg::K_OR, 0, 0, 0, 0);
    else if (word_matches("if")) emit(stt_pkg::K_IF, 0, 0, 0, 0);
    else if (word_matches("else")) emit(stt_pkg::K_ELSE, 0, 0, 0, 0);
    else if (word_matches("while")) emit(stt_pkg::K_WHILE, 0, 0, 0, 0);
    else if (word_matches("for")) emit(stt_pkg::K_FOR, 0, 0, 0, 0);
    else emit_value(stt_pkg::K_IDENT);
  endfunction

  function automatic logic letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [4:0] op_short(input logic [2:0] p);
    case (p)
      stt_pkg::P_SLASH: return stt_pkg::K_SLASH;
      stt_pkg::P_ASSIGN: return stt_pkg::K_ASSIGN;
      stt_pkg::P_LESS: return stt_pkg::K_LESS;
      stt_pkg::P_GREATER: return stt_pkg::K_GREATER;
      default: return stt_pkg::K_EXCL;
    endcase
  endfunction

  function automatic logic [4:0] op_long(input logic [2:0] p);
    case (p)
      stt_pkg::P_ASSIGN: return stt_pkg::K_EQUAL;
      stt_pkg::P_LESS: return stt_pkg::K_LESS_EQUAL;
      stt_pkg::P_GREATER: return stt_pkg::K_GREATER_EQUAL;
      default: return stt_pkg::K_NOT_EQUAL;
    endcase
  endfunction

  function automatic void start_char(input logic [7:0] c);
    case (c)
      8'h0a: emit(stt_pkg::K_EOL, 0, 0, 0, 0);
      "/": op_q = stt_pkg::P_SLASH;
      "=": op_q = stt_pkg::P_ASSIGN;
      "<": op_q = stt_pkg::P_LESS;
      ">": op_q = stt_pkg::P_GREATER;
      "!": op_q = stt_pkg::P_EXCL;
      8'h22, 8'h27: begin
        clear_text();
        mode_q = stt_pkg::M_STRING;
      end
      ":": emit(stt_pkg::K_COLON, 0, 0, 0, 0);
      "+": emit(stt_pkg::K_PLUS, 0, 0, 0, 0);
      "-": emit(stt_pkg::K_MINUS, 0, 0, 0, 0);
      "%": emit(stt_pkg::K_PERCENT, 0, 0, 0, 0);
      "*": emit(stt_pkg::K_ASTERISK, 0, 0, 0, 0);
      "(": emit(stt_pkg::K_LPAREN, 0, 0, 0, 0);
      ")": emit(stt_pkg::K_RPAREN, 0, 0, 0, 0);
      "{": emit(stt_pkg::K_LBRACE, 0, 0, 0, 0);
      "}": emit(stt_pkg::K_RBRACE, 0, 0, 0, 0);
      default: begin
        if (letter(c)) begin
          clear_text();
          append(c);
          mode_q = stt_pkg::M_IDENT;
        end else if (digit(c)) begin
          clear_text();
          append(c);
          mode_q = stt_pkg::M_NUMBER;
        end
      end
    endcase
  endfunction

  function automatic void reset_scan();
    mode_q = stt_pkg::M_IDLE;
    op_q = stt_pkg::P_NONE;
    clear_text();
  endfunction

  function automatic void tokenize_word(input logic kind, input logic [7:0] c);
    logic [2:0] p;
    step_words.delete();
    if (kind) begin
      if (mode_q == stt_pkg::M_IDENT) close_word();
      else if (mode_q == stt_pkg::M_NUMBER)
        emit_value(float_q ? stt_pkg::K_FLOAT : stt_pkg::K_INT);
      else if (mode_q == stt_pkg::M_IDLE && op_q != stt_pkg::P_NONE)
        emit(op_short(op_q), 0, 0, 0, 0);
      emit(stt_pkg::K_EOF, 0, 0, 0, 0);
      reset_scan();
    end else begin
      case (mode_q)
        stt_pkg::M_COMMENT: if (c == 8'h0a) begin
          emit(stt_pkg::K_EOL, 0, 0, 0, 0);
          mode_q = stt_pkg::M_IDLE;
        end
        stt_pkg::M_STRING: begin
          if (c == 8'h22 || c == 8'h27) begin
            emit_value(stt_pkg::K_STRING);
            mode_q = stt_pkg::M_IDLE;
          end else begin
            append(c);
          end
        end
        stt_pkg::M_IDENT: begin
          if (letter(c) || digit(c)) begin
            append(c);
          end else begin
            close_word();
            mode_q = stt_pkg::M_IDLE;
            start_char(c);
          end
        end
        stt_pkg::M_NUMBER: begin
          if (digit(c)) begin
            append(c);
          end else if (c == ".") begin
            append(c);
            float_q = 1'b1;
          end else begin
            emit_value(float_q ? stt_pkg::K_FLOAT : stt_pkg::K_INT);
            mode_q = stt_pkg::M_IDLE;
            start_char(c);
          end
        end
        default: begin
          p = op_q;
          op_q = stt_pkg::P_NONE;
          if (p == stt_pkg::P_NONE) begin
            start_char(c);
          end else if (p == stt_pkg::P_SLASH) begin
            if (c == "/") begin
              mode_q = stt_pkg::M_COMMENT;
            end else begin
              emit(stt_pkg::K_SLASH, 0, 0, 0, 0);
              start_char(c);
            end
          end else if (c == "=") begin
            emit(op_long(p), 0, 0, 0, 0);
          end else begin
            emit(op_short(p), 0, 0, 0, 0);
            start_char(c);
          end
        end
      endcase
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) expected_tokens.push_back(step_words[i]);
  endfunction

  initial begin
    fail_count = 0;
    pending_words = 0;
    reset_scan();
  end

  always @(posedge clk) begin
    token_word_t got;
    token_word_t want;
    if (!rst_n) begin
      reset_scan();
    end else begin
      if (in_mon.valid && in_mon.ready) tokenize_word(in_mon.kind, in_mon.source_char);
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.token_kind, out_mon.is_text, out_mon.text_char, out_mon.text_len,
                out_mon.overflow, out_mon.last};
        if (expected_tokens.size() == 0) begin
          report($sformatf("unexpected word %h", got));
        end else begin
          want = expected_tokens.pop_front();
          if (got.token_kind != want.token_kind)
            report($sformatf("token_kind %0d, want %0d", got.token_kind, want.token_kind));
          if (got.is_text != want.is_text)
            report($sformatf("is_text %0d, want %0d", got.is_text, want.is_text));
          if (got.text_char != want.text_char)
            report($sformatf("text_char %h, want %h", got.text_char, want.text_char));
          if (got.text_len != want.text_len)
            report($sformatf("text_len %0d, want %0d", got.text_len, want.text_len));
          if (got.overflow != want.overflow)
            report($sformatf("overflow %0d, want %0d", got.overflow, want.overflow));
          if (got.last != want.last)
            report($sformatf("last %0d, want %0d", got.last, want.last));
        end
      end
    end
    pending_words = expected_tokens.size();
  end
endmodule

// ===== bench/tb_source_text_tokenizer_unit.sv =====
// Testbench top: drives character words into the tokenizer and gives the verdict.
`timescale 1ns / 100ps
module tb_source_text_tokenizer_unit;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_words;
  int   sent;
  bit   calm;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  source_text_tokenizer_unit u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  stt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.source_char = 8'd0;
    out_ch.ready = 1'b0;
  end

  // sink stalls in bursts
  always @(posedge clk) begin
    int n;
    if (!rst_n || calm || $urandom_range(0, 3) != 0) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      n = $urandom_range(1, 11);
      repeat (n) @(posedge clk);
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_word(input logic kind, input logic [7:0] c);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.source_char <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  // random fragment of source text, with random bytes and end-of-text marks mixed in
  task automatic send_fragment();
    string ops[] = '{"+", "-", "*", "/", "%", "=", "==", "!=", "<", "<=", ">", ">=", "!",
                     "(", ")", "{", "}", ":", "\n", "and ", "or ", "if ", "else ",
                     "while ", "for "};
    int n;
    case ($urandom_range(0, 9))
      0, 1: send_text(ops[$urandom_range(0, ops.size() - 1)]);
      2: begin
        send_word(1'b0, "a" + $urandom_range(0, 25));
        n = $urandom_range(0, 5);
        repeat (n) send_word(1'b0, $urandom_range(0, 1) ? "0" + $urandom_range(0, 9)
                                                       : "A" + $urandom_range(0, 25));
        send_text(" ");
      end
      3: begin
        n = $urandom_range(1, 6);
        repeat (n) send_word(1'b0, $urandom_range(0, 4) ? "0" + $urandom_range(0, 9) : ".");
        send_text(";");
      end
      4: begin
        send_word(1'b0, $urandom_range(0, 1) ? 8'h22 : 8'h27);
        n = $urandom_range(0, 6);
        repeat (n) send_word(1'b0, $urandom_range(32, 126) & 8'hdf | 8'h40);
        send_word(1'b0, 8'h27);
      end
      5: begin
        send_text("//");
        repeat ($urandom_range(0, 4)) send_word(1'b0, $urandom_range(0, 255) & 8'hf7);
        send_text("\n");
      end
      6: send_word(1'b1, $urandom_range(0, 255));
      default: send_word(1'b0, $urandom_range(0, 255));
    endcase
  endtask

  initial begin
    string long_word;
    sent = 0;
    calm = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    long_word = "";
    repeat (34) long_word = {long_word, "w"};
    // directed: every token but ==, keywords, long text, lookahead misses, end-of-text cases
    send_text("if x1<=9.5 and y!=2 or z>=3 else{while(a%b)}:for q=-c*d/e\n");
    send_text("<>!+ =/a //c\x80\n\xff~");
    send_text({long_word, " "});
    send_text("\"hi\nx'");
    send_word(1'b1, 8'h00);
    send_text("if");
    send_word(1'b1, 8'hff);
    send_text("12.");
    send_word(1'b1, 8'h00);
    send_text("//z");
    send_word(1'b1, 8'h00);
    send_text("'open");
    send_word(1'b1, 8'h00);
    send_text("<");
    send_word(1'b1, 8'h00);
    send_text({"'", long_word, "w\""});
    while (sent < 210) begin
      if (sent > 190) calm = 1'b1;
      send_fragment();
    end
    send_word(1'b1, 8'h00);
    in_ch.valid <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule

// ===== source_text_tokenizer_unit.f =====
rtl/core/stt_pkg.sv
rtl/core/stt_if.sv
rtl/core/stt_ram.sv
rtl/core/stt_datapath.sv
rtl/core/stt_ctrl.sv
rtl/core/source_text_tokenizer_unit.sv
rtl/core/stt_checker.sv
bench/stt_checker.sv
bench/tb_source_text_tokenizer_unit.sv
